// File: rtl/binary_to_decimal_ascii_top_macros.svh
// Assertion macros shared by the binary-to-decimal ASCII RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B2D_ASSERT_IMPLY(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define B2D_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// File: rtl/b2d_pkg.sv
// Shared constants, types and the double-dabble step function for the
// binary-to-decimal ASCII converter. No dependencies.
package b2d_pkg;

   localparam int VALUE_W         = 16;
   localparam int INPUT_WIDTH_DEF = 16;
   localparam int DIGITS          = 5;
   localparam int BCD_W           = 4 * DIGITS;
   localparam int DIGIT_IDX_W     = $clog2(DIGITS);
   localparam int DABBLE_STAGES   = 4;
   localparam int CHAR_W          = 6;
   // ASCII '0' is 6'b110000, so a digit character is this prefix over the nibble.
   localparam logic [1:0] ASCII_ZERO_HI = 2'b11;

   typedef struct packed {
      logic [BCD_W-1:0]   bcd;
      logic [VALUE_W-1:0] bits;
   } work_type;

   // One shift-and-add-3 step: correct every digit of five or more, then
   // shift the next binary bit in at the bottom.
   function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                    input logic bit_in);
      logic [BCD_W-1:0] adj;
      adj = bcd;
      for (int d = 0; d < DIGITS; d++) begin
         if (adj[4*d +: 4] >= 4'd5) begin
            adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
         end
      end
      return {adj[BCD_W-2:0], bit_in};
   endfunction

endpackage

// File: rtl/b2d_dabble_stage.sv
// One registered pipeline stage of the double-dabble conversion.
// Depends on b2d_pkg.
module b2d_dabble_stage #(
   parameter int FIRST_STEP  = 0,
   parameter int NUM_STEPS   = 4,
   parameter int TOTAL_STEPS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  b2d_pkg::work_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output b2d_pkg::work_type out_data
);

   logic              valid_ff;
   b2d_pkg::work_type data_ff;
   b2d_pkg::work_type data_in;

   assign in_stall  = valid_ff && out_stall;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Steps past the end of the input width are skipped, which leaves the
   // last stage short when the width does not divide evenly.
   always_comb begin
      data_in = in_data;
      for (int i = 0; i < NUM_STEPS; i++) begin
         if (FIRST_STEP + i < TOTAL_STEPS) begin
            data_in.bcd  = b2d_pkg::dabble_step(data_in.bcd,
                                                data_in.bits[b2d_pkg::VALUE_W-1]);
            data_in.bits = {data_in.bits[b2d_pkg::VALUE_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: rtl/b2d_digit_serializer.sv
// Emits the digits of one packed BCD value as ASCII, most significant first,
// with leading zeros dropped. Depends on b2d_pkg and the macros header.
`include "binary_to_decimal_ascii_top_macros.svh"

module b2d_digit_serializer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_stall,
   input  logic [b2d_pkg::BCD_W-1:0]    in_bcd,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [b2d_pkg::CHAR_W-1:0]   rsp_ascii_char,
   output logic                         rsp_last_char
);

   logic                               active_ff, active_in;
   logic [b2d_pkg::DIGIT_IDX_W-1:0]    idx_ff, idx_in;
   logic [b2d_pkg::BCD_W-1:0]          bcd_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [b2d_pkg::CHAR_W-1:0]         char_ff, char_in;
   logic                               last_ff, last_in;
   logic                               out_free;
   logic                               take;
   logic [b2d_pkg::DIGIT_IDX_W-1:0]    top_digit;
   logic [3:0]                         cur_nib;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   // A new value may load on the cycle its predecessor's last digit leaves.
   assign in_stall = active_ff && !(out_free && (idx_ff == '0));
   assign take     = in_valid && !in_stall;
   assign cur_nib  = bcd_ff[4*idx_ff +: 4];

   // Highest nonzero digit; zero itself prints as one digit.
   always_comb begin
      top_digit = '0;
      for (int d = 0; d < b2d_pkg::DIGITS; d++) begin
         if (in_bcd[4*d +: 4] != 4'd0) begin
            top_digit = b2d_pkg::DIGIT_IDX_W'(d);
         end
      end
   end

   always_comb begin
      active_in    = active_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (out_free) begin
         rsp_valid_in = active_ff;
         char_in      = {b2d_pkg::ASCII_ZERO_HI, cur_nib};
         last_in      = (idx_ff == '0);
         if (active_ff) begin
            if (idx_ff == '0) begin
               active_in = 1'b0;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
      end
      if (take) begin
         active_in = 1'b1;
         idx_in    = top_digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
      if (take) begin
         bcd_ff <= in_bcd;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_last_char  = last_ff;

   `B2D_ASSERT_IMPLY(a_digit_range, clock, reset, rsp_valid_ff, char_ff[3:0] <= 4'd9, "digit out of range")
   `B2D_ASSERT_IMPLY(a_idx_range, clock, reset, active_ff, idx_ff < b2d_pkg::DIGIT_IDX_W'(b2d_pkg::DIGITS), "digit index out of range")
   `B2D_ASSERT_NEXT(a_countdown, clock, reset, active_ff && out_free && (idx_ff != '0), active_ff && (idx_ff == $past(idx_ff) - 1'b1), "digit countdown slipped")
   `B2D_ASSERT_NEXT(a_load, clock, reset, take, active_ff && rsp_valid_ff == $past(active_ff || rsp_valid_ff && rsp_stall), "value load lost")

endmodule

// File: rtl/binary_to_decimal_ascii_top.sv
// Top level of the binary-to-decimal ASCII converter: a four-stage
// double-dabble pipeline feeding a digit serializer. Depends on b2d_pkg,
// b2d_dabble_stage and b2d_digit_serializer.
//
//   Channel   Ports                               Direction   Beat
//   req       req_valid, req_stall, req_value     in          one 16-bit value
//   rsp       rsp_valid, rsp_stall, rsp_ascii_char,
//             rsp_last_char                       out         one ASCII digit
//
// A value of n decimal digits (1 to 5) occupies the serializer until its last
// digit leaves, and only then is the next value taken; the single output port
// of the serializer, one character per cycle unless rsp stalls, sets the rate.
// From req beat to first rsp beat a value passes four conversion stages, the
// serializer load and the output register.
// Reset is synchronous and active high; it clears only the valid and active bits.
// A stall on rsp backs up through the pipeline stage by stage without
// dropping or repeating a beat.
module binary_to_decimal_ascii_top #(
   parameter int INPUT_WIDTH = b2d_pkg::INPUT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [b2d_pkg::VALUE_W-1:0]       req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [b2d_pkg::CHAR_W-1:0]        rsp_ascii_char,
   output logic                              rsp_last_char
);

   // Only the low bits up to the input width are converted, and the port
   // never carries more than sixteen.
   localparam int EFF_W = (INPUT_WIDTH < b2d_pkg::VALUE_W) ? INPUT_WIDTH : b2d_pkg::VALUE_W;
   localparam int STEPS_PER_STAGE = (EFF_W + b2d_pkg::DABBLE_STAGES - 1) / b2d_pkg::DABBLE_STAGES;

   b2d_pkg::work_type stage_data  [0:b2d_pkg::DABBLE_STAGES];
   logic              stage_valid [0:b2d_pkg::DABBLE_STAGES];
   logic              stage_stall [0:b2d_pkg::DABBLE_STAGES];

   // Left-align the used bits so every stage consumes from the top; the
   // ignored high bits fall off the end of the shift.
   assign stage_data[0].bcd  = '0;
   assign stage_data[0].bits = b2d_pkg::VALUE_W'(req_value << (b2d_pkg::VALUE_W - EFF_W));
   assign stage_valid[0]     = req_valid;
   assign req_stall          = stage_stall[0];

   for (genvar k = 0; k < b2d_pkg::DABBLE_STAGES; k++) begin : g_stage
      b2d_dabble_stage #(
         .FIRST_STEP  (k * STEPS_PER_STAGE),
         .NUM_STEPS   (STEPS_PER_STAGE),
         .TOTAL_STEPS (EFF_W)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[k]),
         .in_stall  (stage_stall[k]),
         .in_data   (stage_data[k]),
         .out_valid (stage_valid[k+1]),
         .out_stall (stage_stall[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   // The serializer drops leading zeros and flags the units digit.
   b2d_digit_serializer u_serializer (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (stage_valid[b2d_pkg::DABBLE_STAGES]),
      .in_stall       (stage_stall[b2d_pkg::DABBLE_STAGES]),
      .in_bcd         (stage_data[b2d_pkg::DABBLE_STAGES].bcd),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char)
   );

endmodule

// File: bench/tb_binary_to_decimal_ascii_top.sv
// Self-checking bench for binary_to_decimal_ascii_top: random and directed values in,
// decimal ASCII digit beats out, compared against a predictor held in this file.
// Depends on b2d_pkg and the binary_to_decimal_ascii_top RTL.
module tb_binary_to_decimal_ascii_top;

   localparam int WIDTH_UNDER_TEST = b2d_pkg::INPUT_WIDTH_DEF;
   localparam int RANDOM_VALUES    = 137;
   localparam int IDLE_PERCENT     = 24;
   // Accepted-value window in which neither side idles at random.
   localparam int CALM_FIRST       = 60;
   localparam int CALM_LAST        = 100;
   // Once this many values have gone in, the receiver holds off for a long stretch.
   localparam int HOLD_AFTER       = 120;
   localparam int HOLD_CYCLES      = 150;
   localparam int SETTLE_CYCLES    = 20;
   localparam int TIMEOUT_CYCLES   = 200000;
   localparam logic [b2d_pkg::CHAR_W-1:0] CHAR_ZERO = 6'd48;

   // One ASCII digit beat as the result channel carries it.
   typedef struct {
      logic [b2d_pkg::CHAR_W-1:0] ch;
      logic                       last;
   } digit_beat_type;

   // One value waiting to be sent; drain_first holds it back until every
   // digit already predicted has come out of the block.
   typedef struct {
      logic [b2d_pkg::VALUE_W-1:0] value;
      bit                          drain_first;
   } value_item_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [b2d_pkg::VALUE_W-1:0] req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [b2d_pkg::CHAR_W-1:0]  rsp_ascii_char;
   logic                        rsp_last_char;

   value_item_type values_pending[$];
   digit_beat_type digits_due[$];
   int             total_values = 0;
   int             accepted_count = 0;
   int             error_count = 0;
   int             hold_left = 0;
   bit             hold_done = 1'b0;

   binary_to_decimal_ascii_top #(
      .INPUT_WIDTH(WIDTH_UNDER_TEST)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_ascii_char(rsp_ascii_char),
      .rsp_last_char (rsp_last_char)
   );

   always #6 clock = ~clock;

   // Splits a value into its decimal digits and queues one beat per digit,
   // most significant first. Leading zeros are dropped, but the units digit
   // is always sent, so zero still gives a single '0' flagged as last.
   function automatic void predict_digits(input logic [b2d_pkg::VALUE_W-1:0] value);
      longint unsigned masked;
      int              digit[b2d_pkg::DIGITS];
      int              top;
      digit_beat_type  beat;
      if (WIDTH_UNDER_TEST >= b2d_pkg::VALUE_W) begin
         masked = value;
      end else begin
         masked = value & ((64'd1 << WIDTH_UNDER_TEST) - 1);
      end
      for (int d = 0; d < b2d_pkg::DIGITS; d++) begin
         digit[d] = int'(masked % 10);
         masked   = masked / 10;
      end
      top = 0;
      for (int d = b2d_pkg::DIGITS - 1; d > 0; d--) begin
         if (digit[d] != 0 && top == 0) begin
            top = d;
         end
      end
      for (int d = top; d >= 0; d--) begin
         beat.ch   = CHAR_ZERO + b2d_pkg::CHAR_W'(digit[d]);
         beat.last = (d == 0);
         digits_due.push_back(beat);
      end
   endfunction

   function automatic void add_value(input logic [b2d_pkg::VALUE_W-1:0] value,
                                     input bit drain_first);
      value_item_type item;
      item.value       = value;
      item.drain_first = drain_first;
      values_pending.push_back(item);
      total_values++;
   endfunction

   // Random values are mostly drawn by digit count so that every length of
   // output is common; a few sit right at a power-of-ten boundary.
   function automatic logic [b2d_pkg::VALUE_W-1:0] pick_value();
      int unsigned pick;
      pick = $urandom_range(0, 5);
      case (pick)
         0: return b2d_pkg::VALUE_W'($urandom_range(0, 9));
         1: return b2d_pkg::VALUE_W'($urandom_range(10, 99));
         2: return b2d_pkg::VALUE_W'($urandom_range(100, 999));
         3: return b2d_pkg::VALUE_W'($urandom_range(1000, 9999));
         4: return b2d_pkg::VALUE_W'($urandom);
         default: begin
            case ($urandom_range(0, 7))
               0: return 16'd9;
               1: return 16'd10;
               2: return 16'd99;
               3: return 16'd100;
               4: return 16'd999;
               5: return 16'd1000;
               6: return 16'd9999;
               default: return 16'd10000;
            endcase
         end
      endcase
   endfunction

   // Driver. A value is counted and predicted at the edge where it is taken;
   // the next one is put up only when the channel is free, so a stalled beat
   // keeps its payload. The idle decision never looks at req_stall.
   always @(posedge clock) begin
      bit             calm;
      bit             go;
      value_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_digits(req_value);
            accepted_count <= accepted_count + 1;
         end
         if (!req_valid || !req_stall) begin
            calm = (accepted_count >= CALM_FIRST && accepted_count < CALM_LAST);
            go   = (values_pending.size() != 0);
            if (go && values_pending[0].drain_first && digits_due.size() != 0) begin
               go = 1'b0;
            end
            if (go && !calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
               go = 1'b0;
            end
            if (go) begin
               item = values_pending.pop_front();
               req_valid <= 1'b1;
               req_value <= item.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver. Besides random stalls it holds off once for a long stretch
   // while the sender keeps offering, so the block backs up into its input.
   always @(posedge clock) begin
      bit calm;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         calm = (accepted_count >= CALM_FIRST && accepted_count < CALM_LAST);
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // Monitor. Every digit beat taken is matched against the oldest prediction.
   always @(posedge clock) begin
      digit_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digits_due.size() == 0) begin
            $display("%0t: unexpected digit beat char=%0d last=%0b",
                     $time, rsp_ascii_char, rsp_last_char);
            error_count++;
         end else begin
            want = digits_due.pop_front();
            if (rsp_ascii_char !== want.ch) begin
               $display("%0t: ascii_char expected %0d actual %0d",
                        $time, want.ch, rsp_ascii_char);
               error_count++;
            end
            if (rsp_last_char !== want.last) begin
               $display("%0t: last_char expected %0b actual %0b",
                        $time, want.last, rsp_last_char);
               error_count++;
            end
         end
      end
   end

   // Stimulus and end of run. The directed part covers zero, the ends of the
   // range, every digit count and the edges between them, and bit patterns
   // that set and clear every input bit.
   initial begin
      add_value(16'd0, 1'b0);
      add_value(16'd65535, 1'b0);
      add_value(16'd1, 1'b0);
      add_value(16'd9, 1'b0);
      add_value(16'd10, 1'b0);
      add_value(16'd99, 1'b0);
      add_value(16'd100, 1'b0);
      add_value(16'd999, 1'b0);
      add_value(16'd1000, 1'b0);
      add_value(16'd9999, 1'b0);
      add_value(16'd10000, 1'b0);
      add_value(16'd32768, 1'b0);
      add_value(16'h5555, 1'b0);
      add_value(16'hAAAA, 1'b0);
      add_value(16'd59999, 1'b0);
      add_value(16'd12345, 1'b0);
      add_value(16'd50505, 1'b0);
      add_value(16'd4, 1'b0);
      add_value(16'd5, 1'b0);
      add_value(16'd90, 1'b0);
      add_value(16'd9000, 1'b0);
      add_value(16'd65534, 1'b0);
      add_value(16'd0, 1'b0);
      // The first random value and one later on wait for the block to empty.
      for (int i = 0; i < RANDOM_VALUES; i++) begin
         add_value(pick_value(), (i == 0) || (i == 70));
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // accepted_count is updated with a nonblocking write, so reading it
      // here can only lag, never run ahead of the driver.
      while (accepted_count != total_values) @(posedge clock);
      while (digits_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (digits_due.size() != 0) begin
         $display("%0t: %0d digit beats never arrived", $time, digits_due.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog for a block that hangs or drops beats.
   initial begin
      #(12 * TIMEOUT_CYCLES);
      $display("%0t: timeout", $time);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
